// ----- hw/rtl/lps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg
// Shared sizes, command and status codes, and the controller/datapath
// interface structs of the linear prime sieve lookup core.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int TABLE_SIZE  = 1048576;
    localparam int PRIME_SLOTS = 131072;

    localparam int VAL_W  = 20;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int PCNT_W = 18;

    localparam int TAB_AW = $clog2(TABLE_SIZE);
    localparam int PS_AW  = $clog2(PRIME_SLOTS);
    localparam int CNT_W  = $clog2(PRIME_SLOTS + 1);

    localparam logic [VAL_W-1:0] LIMIT_RESET = VAL_W'(1048575);

    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VALUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INDEX = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;

    typedef struct packed {
        logic idle;
        logic accept;
        logic clr;
        logic lpi_chk;
        logic p_rd;
        logic p_mul;
        logic p_chk;
        logic finish;
    } lps_ctl_t;

    typedef struct packed {
        logic in_build;
        logic clr_last;
        logic i_over;
        logic lp_new;
        logic store_full;
        logic j_end;
        logic p_stop;
    } lps_sts_t;

endpackage

// ----- hw/rtl/lps_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lps_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_ctrl
// Sequencer for build (clear pass, sieve walk, marking loop) and queries.
// ----------------------------------------------------------------------------
module lps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lps_pkg::lps_sts_t sts,
    output lps_pkg::lps_ctl_t ctl,
    output logic              busy
);
    import lps_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CLEAR   = 8'b0000_0010,
        S_LPI_RD  = 8'b0000_0100,
        S_LPI_CHK = 8'b0000_1000,
        S_P_RD    = 8'b0001_0000,
        S_P_MUL   = 8'b0010_0000,
        S_P_CHK   = 8'b0100_0000,
        S_RESULT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.idle = 1'b1;
                if (start)
                begin
                    ctl.accept = 1'b1;
                    state_next = sts.in_build ? S_CLEAR : S_RESULT;
                end
            end
            S_CLEAR:
            begin
                ctl.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_LPI_RD;
                end
            end
            S_LPI_RD:
            begin
                state_next = sts.i_over ? S_RESULT : S_LPI_CHK;
            end
            S_LPI_CHK:
            begin
                ctl.lpi_chk = 1'b1;
                state_next  = (sts.lp_new && sts.store_full) ? S_RESULT : S_P_RD;
            end
            S_P_RD:
            begin
                ctl.p_rd   = 1'b1;
                state_next = sts.j_end ? S_LPI_RD : S_P_MUL;
            end
            S_P_MUL:
            begin
                ctl.p_mul  = 1'b1;
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                ctl.p_chk  = 1'b1;
                state_next = sts.p_stop ? S_LPI_RD : S_P_RD;
            end
            S_RESULT:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- hw/rtl/lps_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_datapath
// Limit register, sieve counters, factor table and prime store, result beat.
// ----------------------------------------------------------------------------
module lps_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lps_pkg::CMD_W-1:0]   cmd,
    input  logic [lps_pkg::VAL_W-1:0]   operand,
    input  logic                        cfg_wr_en,
    input  logic [lps_pkg::VAL_W-1:0]   cfg_wr_data,
    input  lps_pkg::lps_ctl_t           ctl,
    output lps_pkg::lps_sts_t           sts,
    output logic                        done,
    output logic                        is_prime,
    output logic [lps_pkg::VAL_W-1:0]   least_factor,
    output logic [lps_pkg::VAL_W-1:0]   prime_value,
    output logic [lps_pkg::PCNT_W-1:0]  prime_count,
    output logic [lps_pkg::STAT_W-1:0]  status
);
    import lps_pkg::*;

    logic [VAL_W-1:0]   limit_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [VAL_W-1:0]   opnd_reg;
    logic [VAL_W-1:0]   top_reg;
    logic [VAL_W-1:0]   covered_reg;
    logic [VAL_W-1:0]   clr_addr_reg;
    logic [VAL_W:0]     i_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [CNT_W-1:0]   fc_reg;
    logic               built_reg;
    logic [VAL_W-1:0]   lpi_reg;
    logic [VAL_W-1:0]   p_reg;
    logic [2*VAL_W-1:0] prod_reg;
    logic               done_reg;
    logic               is_prime_reg;
    logic [VAL_W-1:0]   least_factor_reg;
    logic [VAL_W-1:0]   prime_value_reg;
    logic [PCNT_W-1:0]  prime_count_reg;
    logic [STAT_W-1:0]  status_reg;

    logic [VAL_W-1:0]   top_clip;
    logic [VAL_W-1:0]   tab_rdata;
    logic [VAL_W-1:0]   st_rdata;
    logic               tab_we;
    logic [TAB_AW-1:0]  tab_waddr;
    logic [VAL_W-1:0]   tab_wdata;
    logic [TAB_AW-1:0]  tab_raddr;
    logic               st_we;
    logic [PS_AW-1:0]   st_raddr;
    logic               new_prime;
    logic               i_step;

    logic               res_isp;
    logic [VAL_W-1:0]   res_lf;
    logic [VAL_W-1:0]   res_pv;
    logic [STAT_W-1:0]  res_st;

    assign top_clip = (32'(limit_reg) > TABLE_SIZE - 1) ? VAL_W'(TABLE_SIZE - 1) : limit_reg;

    // status to controller
    assign sts.in_build   = (cmd == CMD_BUILD);
    assign sts.clr_last   = (clr_addr_reg == top_reg);
    assign sts.i_over     = (i_reg > {1'b0, top_reg});
    assign sts.lp_new     = (tab_rdata == '0);
    assign sts.store_full = (32'(fc_reg) >= PRIME_SLOTS);
    assign sts.j_end      = (j_reg >= fc_reg);
    assign sts.p_stop     = (p_reg > lpi_reg) || (prod_reg > {{VAL_W{1'b0}}, top_reg});

    assign new_prime = ctl.lpi_chk && sts.lp_new && !sts.store_full;
    assign i_step    = (ctl.p_rd && sts.j_end) || (ctl.p_chk && sts.p_stop);

    // factor table port muxing
    assign tab_we    = ctl.clr || new_prime || (ctl.p_chk && !sts.p_stop);
    assign tab_raddr = ctl.idle ? TAB_AW'(operand) : TAB_AW'(i_reg);
    assign st_raddr  = ctl.idle ? PS_AW'(operand) : PS_AW'(j_reg);
    assign st_we     = new_prime;

    always_comb
    begin
        priority if (ctl.clr)
        begin
            tab_waddr = TAB_AW'(clr_addr_reg);
            tab_wdata = '0;
        end
        else if (ctl.lpi_chk)
        begin
            tab_waddr = TAB_AW'(i_reg);
            tab_wdata = VAL_W'(i_reg);
        end
        else
        begin
            tab_waddr = TAB_AW'(prod_reg);
            tab_wdata = p_reg;
        end
    end

    lps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_factor_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    lps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (PRIME_SLOTS)
    ) u_prime_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (PS_AW'(fc_reg)),
        .wdata (VAL_W'(i_reg)),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            fc_reg      <= '0;
            built_reg   <= 1'b0;
            covered_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (ctl.accept && sts.in_build)
            begin
                fc_reg      <= '0;
                covered_reg <= top_clip;
            end
            if (new_prime)
            begin
                fc_reg <= fc_reg + 1'b1;
            end
            if (ctl.lpi_chk && sts.lp_new && sts.store_full)
            begin
                covered_reg <= VAL_W'(i_reg - 1'b1);
            end
            if (ctl.finish && (cmd_reg == CMD_BUILD))
            begin
                built_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg      <= cmd;
            opnd_reg     <= operand;
            top_reg      <= top_clip;
            clr_addr_reg <= '0;
            i_reg        <= (VAL_W + 1)'(2);
        end
        if (ctl.clr)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
        if (ctl.lpi_chk)
        begin
            lpi_reg <= sts.lp_new ? VAL_W'(i_reg) : tab_rdata;
            j_reg   <= '0;
        end
        if (ctl.p_mul)
        begin
            p_reg    <= st_rdata;
            prod_reg <= (2 * VAL_W)'(st_rdata) * (2 * VAL_W)'(i_reg[VAL_W-1:0]);
        end
        if (ctl.p_chk && !sts.p_stop)
        begin
            j_reg <= j_reg + 1'b1;
        end
        if (i_step)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (ctl.finish)
        begin
            is_prime_reg     <= res_isp;
            least_factor_reg <= res_lf;
            prime_value_reg  <= res_pv;
            prime_count_reg  <= PCNT_W'(fc_reg);
            status_reg       <= res_st;
        end
    end

    // result beat
    always_comb
    begin
        res_isp = 1'b0;
        res_lf  = '0;
        res_pv  = '0;
        res_st  = ST_OK;
        unique case (cmd_reg)
            CMD_BUILD:
            begin
                res_st = ST_OK;
            end
            CMD_VALUE:
            begin
                priority if (!built_reg)
                begin
                    res_st = ST_NOT_BUILT;
                end
                else if (opnd_reg > covered_reg)
                begin
                    res_st = ST_RANGE;
                end
                else
                begin
                    res_lf  = tab_rdata;
                    res_isp = (opnd_reg >= VAL_W'(2)) && (tab_rdata == opnd_reg);
                end
            end
            CMD_INDEX:
            begin
                priority if (!built_reg)
                begin
                    res_st = ST_NOT_BUILT;
                end
                else if (32'(opnd_reg) >= 32'(fc_reg))
                begin
                    res_st = ST_RANGE;
                end
                else
                begin
                    res_pv = st_rdata;
                end
            end
            default:
            begin
                res_st = ST_RANGE;
            end
        endcase
    end

    assign done         = done_reg;
    assign is_prime     = is_prime_reg;
    assign least_factor = least_factor_reg;
    assign prime_value  = prime_value_reg;
    assign prime_count  = prime_count_reg;
    assign status       = status_reg;

endmodule

// ----- hw/rtl/linear_prime_sieve_lookup_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_prime_sieve_lookup_core
// Linear sieve of Eratosthenes with value and prime-index lookups.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result beat
// appears on the result ports for one cycle with done high, and the receiver
// cannot stall it. A query (value or prime index) passes from the accept
// state through the result state to the registered done, with one registered
// read of the factor table or prime store; busy is low again in the done
// cycle. A build first runs a clearing pass over entries 0..L of the factor
// table (L the limit clipped to the table), then walks i = 2..L, each i a
// read and a check of its factor entry followed by the marking steps of the
// prime loop (read store, multiply, compare/write); the loop ends when the
// compare stops it or the stored primes run out. The build ends early if a
// new prime finds the prime store full. The limit register may be written
// only while idle.
// ----------------------------------------------------------------------------
module linear_prime_sieve_lookup_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lps_pkg::CMD_W-1:0]   cmd,
    input  logic [lps_pkg::VAL_W-1:0]   operand,
    input  logic                        cfg_wr_en,
    input  logic [lps_pkg::VAL_W-1:0]   cfg_wr_data,
    output logic                        done,
    output logic                        is_prime,
    output logic [lps_pkg::VAL_W-1:0]   least_factor,
    output logic [lps_pkg::VAL_W-1:0]   prime_value,
    output logic [lps_pkg::PCNT_W-1:0]  prime_count,
    output logic [lps_pkg::STAT_W-1:0]  status
);
    import lps_pkg::*;

    lps_ctl_t ctl;
    lps_sts_t sts;

    lps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    lps_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operand      (operand),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .ctl          (ctl),
        .sts          (sts),
        .done         (done),
        .is_prime     (is_prime),
        .least_factor (least_factor),
        .prime_value  (prime_value),
        .prime_count  (prime_count),
        .status       (status)
    );

endmodule

// ----- hw/rtl/lps_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks of the sieve core, bound to the top level.
// ----------------------------------------------------------------------------
module lps_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        done,
    input  logic                        is_prime,
    input  logic [lps_pkg::VAL_W-1:0]   least_factor,
    input  logic [lps_pkg::VAL_W-1:0]   prime_value,
    input  logic [lps_pkg::STAT_W-1:0]  status
);
    import lps_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result beats");

    a_not_built_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NOT_BUILT)) |->
            (!is_prime && (least_factor == '0) && (prime_value == '0)))
        else $error("not-built beat carries data");

    a_prime_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_prime) |-> ((status == ST_OK) && (least_factor >= VAL_W'(2))))
        else $error("prime flag with bad status or factor");

endmodule

bind linear_prime_sieve_lookup_core lps_checker u_lps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .is_prime     (is_prime),
    .least_factor (least_factor),
    .prime_value  (prime_value),
    .status       (status)
);
